// ----- src/key_exchange_initiator_control_macros.svh -----
// ----------------------------------------------------------------------------
// Key exchange initiator control assertion macros
// Property helpers for the port checker; expect clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef KEY_EXCHANGE_INITIATOR_CONTROL_MACROS_SVH
`define KEY_EXCHANGE_INITIATOR_CONTROL_MACROS_SVH

// same-cycle implication
`define KXIC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KXIC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/kxic_pkg.sv -----
// ----------------------------------------------------------------------------
// Key exchange initiator control package
// Word types, configuration registers, protocol state and status codes.
// ----------------------------------------------------------------------------
package kxic_pkg;

  localparam int SEQ_BITS_DEFAULT = 32;
  localparam int CFG_INDEX_W      = 2;
  localparam int CFG_DATA_W       = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_TX  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_REPLY2  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_REPLY4  = 2'd3;

  localparam logic [7:0]  MAX_TX_RESET  = 8'd3;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [7:0]  REPLY2_RESET  = 8'd2;
  localparam logic [7:0]  REPLY4_RESET  = 8'd4;

  localparam logic [1:0] MSG_NONE   = 2'd0;
  localparam logic [1:0] MSG_VALID  = 2'd1;
  localparam logic [1:0] MSG_REPEAT = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'd0,
    ST_BUILD1  = 4'd1,
    ST_SEND1   = 4'd2,
    ST_WAIT1   = 4'd3,
    ST_VERIFY3 = 4'd4,
    ST_BUILD3  = 4'd5,
    ST_SEND3   = 4'd6,
    ST_WAIT3   = 4'd7,
    ST_VERIFY5 = 4'd8,
    ST_DONE    = 4'd9
  } proto_state_t;

  typedef struct packed {
    logic [7:0]  max_retransmissions;
    logic [15:0] retransmit_timeout_ms;
    logic [7:0]  reply2_type;
    logic [7:0]  reply4_type;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  msg_status;
    logic [7:0]  msg_type;
    logic [31:0] now_ms;
    logic        mac_ok;
    logic        sig_ok;
    logic [31:0] rx_seq;
    logic [31:0] rx_ack_seq;
    logic [31:0] random_seq;
  } step_t;

  typedef struct packed {
    logic [3:0]  next_state;
    logic        build_first;
    logic        build_third;
    logic        transmit_first;
    logic        transmit_third;
    logic        consume_message;
    logic        abort_session;
    logic [31:0] own_seq;
    logic [31:0] expected_seq;
    logic        exchange_active;
    logic [7:0]  send_count;
  } result_t;

endpackage

// ----- src/kxic_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Key exchange initiator control configuration registers
// Write-only register file for retry limit, timeout and reply type codes.
// ----------------------------------------------------------------------------
module kxic_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [kxic_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [kxic_pkg::CFG_DATA_W-1:0]     cfg_data,
  output kxic_pkg::cfg_t                      cfg
);
  import kxic_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_retransmissions   <= MAX_TX_RESET;
      cfg.retransmit_timeout_ms <= TIMEOUT_RESET;
      cfg.reply2_type           <= REPLY2_RESET;
      cfg.reply4_type           <= REPLY4_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MAX_TX:  cfg.max_retransmissions   <= cfg_data[7:0];
        CFG_TIMEOUT: cfg.retransmit_timeout_ms <= cfg_data;
        CFG_REPLY2:  cfg.reply2_type           <= cfg_data[7:0];
        CFG_REPLY4:  cfg.reply4_type           <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- src/kxic_core.sv -----
// ----------------------------------------------------------------------------
// Key exchange initiator control core
// Protocol state, counters and sequence registers with one-step update logic.
// ----------------------------------------------------------------------------
module kxic_core #(
  parameter int SEQ_BITS = kxic_pkg::SEQ_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  kxic_pkg::step_t   item,
  input  kxic_pkg::cfg_t    cfg,
  output kxic_pkg::result_t result
);
  import kxic_pkg::*;

  proto_state_t        state, state_next;
  logic [7:0]          tx_count, tx_count_next;
  logic [31:0]         last_send, last_send_next;
  logic [SEQ_BITS-1:0] own_sequence, own_sequence_next;
  logic [SEQ_BITS-1:0] partner_sequence, partner_sequence_next;
  logic                active, active_next;

  logic [63:0]         rnd_ext, rx_seq_ext, ack_ext, own_ext, partner_ext;
  logic [SEQ_BITS-1:0] rnd_seq, rx_seq_inc, ack_seq;
  logic [31:0]         elapsed;
  logic [7:0]          expect_type;
  logic                timed_out, can_send, msg_valid, msg_repeat;
  logic                reply_match, wait_reject, wait_resend;
  logic                verify3_ok, verify5_ok;
  logic                b1, b3, t1, t3, cons, ab;

  assign rnd_ext    = {32'b0, item.random_seq};
  assign rx_seq_ext = {32'b0, item.rx_seq};
  assign ack_ext    = {32'b0, item.rx_ack_seq};
  assign rnd_seq    = rnd_ext[SEQ_BITS-1:0];
  assign ack_seq    = ack_ext[SEQ_BITS-1:0];
  assign rx_seq_inc = rx_seq_ext[SEQ_BITS-1:0] + SEQ_BITS'(1);

  assign elapsed     = item.now_ms - last_send;
  assign timed_out   = elapsed > {16'b0, cfg.retransmit_timeout_ms};
  assign can_send    = tx_count < cfg.max_retransmissions;
  assign expect_type = (state == ST_WAIT3) ? cfg.reply4_type : cfg.reply2_type;
  assign msg_valid   = item.msg_status == MSG_VALID;
  assign msg_repeat  = item.msg_status == MSG_REPEAT;
  assign reply_match = msg_valid && (item.msg_type == expect_type);
  assign wait_reject = msg_repeat || (msg_valid && !reply_match);
  assign wait_resend = wait_reject || (!msg_valid && !msg_repeat && timed_out);
  assign verify3_ok  = item.mac_ok && item.sig_ok;
  assign verify5_ok  = item.mac_ok && (own_sequence == ack_seq);

  always_comb begin
    case (state)
      ST_IDLE:    state_next = ST_BUILD1;
      ST_BUILD1:  state_next = ST_SEND1;
      ST_SEND1:   state_next = can_send ? ST_WAIT1 : ST_IDLE;
      ST_WAIT1:   state_next = reply_match ? ST_VERIFY3 :
                               wait_resend ? ST_SEND1 : ST_WAIT1;
      ST_VERIFY3: state_next = verify3_ok ? ST_BUILD3 : ST_SEND1;
      ST_BUILD3:  state_next = ST_SEND3;
      ST_SEND3:   state_next = can_send ? ST_WAIT3 : ST_IDLE;
      ST_WAIT3:   state_next = reply_match ? ST_VERIFY5 :
                               wait_resend ? ST_SEND3 : ST_WAIT3;
      ST_VERIFY5: state_next = verify5_ok ? ST_DONE : ST_SEND3;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    b1                    = 1'b0;
    b3                    = 1'b0;
    t1                    = 1'b0;
    t3                    = 1'b0;
    cons                  = 1'b0;
    ab                    = 1'b0;
    tx_count_next         = tx_count;
    last_send_next        = last_send;
    own_sequence_next     = own_sequence;
    partner_sequence_next = partner_sequence;
    active_next           = active;
    case (state)
      ST_IDLE: begin
        active_next           = 1'b0;
        last_send_next        = '0;
        tx_count_next         = '0;
        own_sequence_next     = rnd_seq;
        partner_sequence_next = '0;
      end
      ST_BUILD1, ST_BUILD3: begin
        own_sequence_next = own_sequence + SEQ_BITS'(1);
        b1                = state == ST_BUILD1;
        b3                = state == ST_BUILD3;
      end
      ST_SEND1, ST_SEND3: begin
        if (can_send) begin
          tx_count_next  = tx_count + 8'd1;
          last_send_next = item.now_ms;
          t1             = state == ST_SEND1;
          t3             = state == ST_SEND3;
        end else begin
          ab = 1'b1;
        end
      end
      ST_WAIT1, ST_WAIT3: begin
        cons = wait_reject;
      end
      ST_VERIFY3: begin
        cons = 1'b1;
        if (verify3_ok) begin
          active_next           = 1'b1;
          tx_count_next         = '0;
          last_send_next        = '0;
          partner_sequence_next = rx_seq_inc;
        end
      end
      ST_VERIFY5: begin
        cons = 1'b1;
        if (verify5_ok) begin
          partner_sequence_next = rx_seq_inc;
        end
      end
      default: ;
    endcase
  end

  assign own_ext     = 64'(own_sequence_next);
  assign partner_ext = 64'(partner_sequence_next);

  always_comb begin
    result.next_state      = state_next;
    result.build_first     = b1;
    result.build_third     = b3;
    result.transmit_first  = t1;
    result.transmit_third  = t3;
    result.consume_message = cons;
    result.abort_session   = ab;
    result.own_seq         = own_ext[31:0];
    result.expected_seq    = partner_ext[31:0];
    result.exchange_active = active_next;
    result.send_count      = tx_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      tx_count         <= '0;
      last_send        <= '0;
      own_sequence     <= '0;
      partner_sequence <= '0;
      active           <= 1'b0;
    end else if (advance) begin
      state            <= state_next;
      tx_count         <= tx_count_next;
      last_send        <= last_send_next;
      own_sequence     <= own_sequence_next;
      partner_sequence <= partner_sequence_next;
      active           <= active_next;
    end
  end

endmodule

// ----- src/key_exchange_initiator_control.sv -----
// ----------------------------------------------------------------------------
// Key exchange initiator control: input word register, then result register.
// One word per cycle unless stalled; one protocol step per word in the core.
// Synchronous reset to idle with empty word registers and default registers.
// ----------------------------------------------------------------------------
module key_exchange_initiator_control #(
  parameter int SEQ_BITS = kxic_pkg::SEQ_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [kxic_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [kxic_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             step_valid,
  output logic                             step_stall,
  input  kxic_pkg::step_t                  step_data,
  output logic                             result_valid,
  input  logic                             result_stall,
  output kxic_pkg::result_t                result_data
);
  import kxic_pkg::*;

  cfg_t    cfg;
  step_t   item;
  logic    item_valid;
  result_t core_result;
  logic    out_ready;
  logic    advance;

  assign out_ready  = !result_valid || !result_stall;
  assign advance    = item_valid && out_ready;
  assign step_stall = item_valid && !out_ready;

  kxic_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kxic_core #(
    .SEQ_BITS (SEQ_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .cfg     (cfg),
    .result  (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!step_stall) begin
      item_valid <= step_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!step_stall && step_valid) begin
      item <= step_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_ready) begin
      result_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_data <= core_result;
    end
  end

endmodule

// ----- src/kxic_checker.sv -----
// ----------------------------------------------------------------------------
// Key exchange initiator control port checker
// Port-level properties on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "key_exchange_initiator_control_macros.svh"

module kxic_checker (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_stall,
  input kxic_pkg::result_t result_data
);
  import kxic_pkg::*;

  logic [5:0] strobes;

  assign strobes = {result_data.build_first, result_data.build_third,
                    result_data.transmit_first, result_data.transmit_third,
                    result_data.consume_message, result_data.abort_session};

  `KXIC_ASSERT_NEXT(a_hold_result, result_valid && result_stall, result_valid && $stable(result_data), "stalled result word changed")
  `KXIC_ASSERT_IMP(a_one_strobe, result_valid, $onehot0(strobes), "more than one strobe raised")
  `KXIC_ASSERT_IMP(a_abort_idle, result_valid && result_data.abort_session, result_data.next_state == ST_IDLE, "abort without return to idle")
  `KXIC_ASSERT_IMP(a_build_send, result_valid && result_data.build_first, result_data.next_state == ST_SEND1, "first build not followed by send")

endmodule

bind key_exchange_initiator_control kxic_checker u_kxic_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_data  (result_data)
);
